>>> design/lpc_pkg.sv
`timescale 1ns / 1ps

package lpc_pkg;

  localparam int unsigned MID_DEPTH_DEFAULT = 2;
  localparam int unsigned OUT_DEPTH_DEFAULT = 2;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_FOR_ZERO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_MAGIC = 2'd1;

  localparam logic [15:0] MIN_FRAME_BYTES = 16'd34;
  localparam logic [7:0] TYPE_HI = 8'hBE;
  localparam logic [7:0] TYPE_LO = 8'hEF;
  localparam logic [15:0] PROBE_TYPE = {TYPE_HI, TYPE_LO};
  localparam logic [31:0] END_LAST = 32'hFFFF_FFFF;
  localparam logic [31:0] END_NORMAL = 32'h0000_0000;

  typedef struct packed {
    logic [15:0] frame_size;
    logic        fcs_bad;
    logic [15:0] type_field;
    logic [31:0] magic_word;
    logic [31:0] sequence_number;
    logic [31:0] end_word;
    logic [63:0] timestamp_ns;
    logic        port_id;
  } frame_t;

  typedef struct packed {
    logic               accepted;
    logic               diff_valid;
    logic signed [63:0] latency_diff;
    logic               sequence_done;
    logic               problem_seen;
    logic               recording;
  } result_t;

  // Classified frame handed from the front end to the pairing engine.
  typedef struct packed {
    logic        probe;
    logic        wait_skip;
    logic        last;
    logic [31:0] seq;
    logic [63:0] stamp;
    logic        port;
  } probe_t;

endpackage

>>> design/lpc_fifo.sv
`timescale 1ns / 1ps

module lpc_fifo #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> design/lpc_front.sv
`timescale 1ns / 1ps

module lpc_front
  import lpc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  frame_t                frame,
  output probe_t                item
);

  logic        wait_for_zero;
  logic [31:0] probe_magic;
  logic        is_last;
  logic        end_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_for_zero <= 1'b0;
      probe_magic   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WAIT_FOR_ZERO: wait_for_zero <= cfg_data[0];
        CFG_PROBE_MAGIC:   probe_magic   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign is_last = (frame.end_word == END_LAST);
  assign end_ok  = is_last || (frame.end_word == END_NORMAL);

  always_comb begin
    item.probe     = (frame.frame_size >= MIN_FRAME_BYTES) && !frame.fcs_bad &&
                     (frame.type_field == PROBE_TYPE) &&
                     (frame.magic_word == probe_magic) && end_ok;
    item.wait_skip = wait_for_zero && (frame.sequence_number != '0);
    item.last      = is_last;
    item.seq       = frame.sequence_number;
    item.stamp     = frame.timestamp_ns;
    item.port      = frame.port_id;
  end

endmodule

>>> design/lpc_back.sv
`timescale 1ns / 1ps

module lpc_back
  import lpc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  probe_t  item,
  input  logic    item_avail,
  input  logic    out_full,
  output logic    take,
  output result_t result
);

  logic        locked;
  logic        half_pending;
  logic [31:0] last_sequence;
  logic [63:0] last_time;
  logic        last_port;
  logic        problems;

  logic        locked_next;
  logic        half_pending_next;
  logic        problems_next;
  logic        proceed;
  logic        back_time;
  logic        hp;
  logic [31:0] ls;
  logic        seq_diff;
  logic [63:0] fwd_diff;
  logic [63:0] rev_diff;

  assign take      = item_avail && !out_full;
  assign back_time = item.probe && (item.stamp < last_time);
  assign proceed   = item.probe && !(!locked && item.wait_skip);
  assign hp        = locked ? half_pending : 1'b0;
  assign ls        = locked ? last_sequence : '0;
  assign seq_diff  = (item.seq != ls);
  assign fwd_diff  = item.stamp - last_time;
  assign rev_diff  = last_time - item.stamp;

  always_comb begin
    locked_next          = locked;
    half_pending_next    = half_pending;
    problems_next        = problems | back_time;
    result.accepted      = 1'b0;
    result.diff_valid    = 1'b0;
    result.latency_diff  = '0;
    result.sequence_done = 1'b0;
    if (proceed) begin
      result.accepted = 1'b1;
      locked_next     = 1'b1;
      if (!locked) begin
        problems_next = 1'b0;
      end
      if (hp) begin
        half_pending_next   = seq_diff;
        problems_next       = problems_next | (last_port == item.port) | seq_diff;
        result.diff_valid   = 1'b1;
        result.latency_diff = last_port ? rev_diff : fwd_diff;
        if (item.last) begin
          locked_next          = 1'b0;
          result.sequence_done = 1'b1;
        end
      end else begin
        half_pending_next = !(item.seq < ls);
        problems_next     = problems_next | (item.seq < ls);
      end
    end
    result.problem_seen = problems_next;
    result.recording    = locked_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      locked        <= 1'b0;
      half_pending  <= 1'b0;
      last_sequence <= '0;
      last_time     <= '0;
      last_port     <= 1'b0;
      problems      <= 1'b0;
    end else if (take) begin
      locked       <= locked_next;
      half_pending <= half_pending_next;
      problems     <= problems_next;
      if (proceed) begin
        last_sequence <= item.seq;
        last_time     <= item.stamp;
        last_port     <= item.port;
      end
    end
  end

endmodule

>>> design/latency_probe_pair_checker_top.sv
`timescale 1ns / 1ps

// Latency probe pair checker. Push one captured frame summary per cycle; every frame yields
// exactly one result. Each frame is classified as it is pushed and written into the classification
// queue; the pairing engine takes it from there when the result queue has room and writes its
// result into the result queue, which shows it at once. Throughput is one frame per cycle while
// the result queue has room, set by the pairing engine, which computes two 64-bit differences
// and a 64-bit compare per frame. Configuration registers are written through the
// cfg port, which is always ready, and must only be changed while no frames are in flight.
module latency_probe_pair_checker_top
  import lpc_pkg::*;
#(
  parameter int unsigned MID_DEPTH = MID_DEPTH_DEFAULT,
  parameter int unsigned OUT_DEPTH = OUT_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  frame_t                frame,
  output logic                  empty,
  input  logic                  pop,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  probe_t  front_item;
  probe_t  mid_item;
  logic    mid_empty;
  logic    out_full;
  logic    take;
  result_t back_result;

  assign cfg_ready = 1'b1;

  lpc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .frame     (frame),
    .item      (front_item)
  );

  lpc_fifo #(
    .WIDTH ($bits(probe_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (front_item),
    .full  (full),
    .pop   (take),
    .rdata (mid_item),
    .empty (mid_empty)
  );

  lpc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (mid_item),
    .item_avail (!mid_empty),
    .out_full   (out_full),
    .take       (take),
    .result     (back_result)
  );

  lpc_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (take),
    .wdata (back_result),
    .full  (out_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

endmodule

>>> design/lpc_checker.sv
`timescale 1ns / 1ps

module lpc_checker
  import lpc_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    empty,
  input result_t result
);

  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_diff_zero_unless_pair: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.diff_valid) |->
      (result.latency_diff == '0 && !result.sequence_done))
    else $error("difference or done flag set without a completed pair");

  a_pair_needs_accept: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.diff_valid) |-> result.accepted)
    else $error("pair completed by a frame that was not accepted");

  a_done_stops_recording: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.sequence_done) |-> !result.recording)
    else $error("still recording after the sequence ended");

  a_accept_keeps_lock: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.accepted) |-> (result.recording || result.sequence_done))
    else $error("accepted frame left the block unlocked");

endmodule

bind latency_probe_pair_checker_top lpc_checker u_lpc_checker (
  .clk    (clk),
  .rst    (rst),
  .empty  (empty),
  .result (result)
);
